// File: hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, constants and the reciprocal table of the stereo echo unit.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int MAX_ECHOES_DEF    = 16;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int RECIP_W  = 22;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int TAP_K_W  = 5;
    localparam int TAP_K_MAX = 31;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_TAP_SPACING  = 2'd0;
    localparam logic [1:0] REG_ECHO_COUNT   = 2'd1;
    localparam logic [1:0] REG_ALT_POLARITY = 2'd2;
    localparam logic [1:0] REG_DIVIDER_MODE = 2'd3;

    localparam logic [7:0] TAP_SPACING_RST  = 8'd88;
    localparam logic [4:0] ECHO_COUNT_RST   = 5'd11;
    localparam logic       ALT_POLARITY_RST = 1'b1;
    localparam logic       DIVIDER_MODE_RST = 1'b0;

    typedef struct packed {
        logic [7:0] tap_spacing;
        logic [4:0] echo_count;
        logic       alternate_polarity;
        logic       divider_mode;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } frame_out_t;

    typedef struct packed {
        logic               valid;
        logic [TAP_K_W-1:0] k;
        logic               unwritten;
    } tap_ctl_t;

    // ceil(2^22 / (k+1)); exact floor division for magnitudes up to 2^15
    function automatic logic [RECIP_W-1:0] recip_of(input logic [TAP_K_W-1:0] k);
        logic [RECIP_W-1:0] m;
        case (k)
            5'd1:    m = 22'd2097152;
            5'd2:    m = 22'd1398102;
            5'd3:    m = 22'd1048576;
            5'd4:    m = 22'd838861;
            5'd5:    m = 22'd699051;
            5'd6:    m = 22'd599187;
            5'd7:    m = 22'd524288;
            5'd8:    m = 22'd466034;
            5'd9:    m = 22'd419431;
            5'd10:   m = 22'd381301;
            5'd11:   m = 22'd349526;
            5'd12:   m = 22'd322639;
            5'd13:   m = 22'd299594;
            5'd14:   m = 22'd279621;
            5'd15:   m = 22'd262144;
            5'd16:   m = 22'd246724;
            5'd17:   m = 22'd233017;
            5'd18:   m = 22'd220753;
            5'd19:   m = 22'd209716;
            5'd20:   m = 22'd199729;
            5'd21:   m = 22'd190651;
            5'd22:   m = 22'd182362;
            5'd23:   m = 22'd174763;
            5'd24:   m = 22'd167773;
            5'd25:   m = 22'd161320;
            5'd26:   m = 22'd155345;
            5'd27:   m = 22'd149797;
            5'd28:   m = 22'd144632;
            5'd29:   m = 22'd139811;
            5'd30:   m = 22'd135301;
            5'd31:   m = 22'd131072;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/stereo_multi_tap_echo_unit.sv
// ----------------------------------------------------------------------------
// stereo_multi_tap_echo_unit
// Stereo multi-tap echo: sums up to echo_count scaled past frames per channel.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one stereo input frame per transfer; the frame
//   is written into the history memory in the cycle it is taken.
//   m_valid/m_ready/m_data return one output frame per input frame.
//   One history read is issued per tap, one tap per cycle, through a
//   three-stage tap pipeline (memory read, multiply, accumulate).
//   With T taps (T = min(echo_count, MAX_ECHOES)) and T > 0, the T reads are
//   issued, the tap pipeline drains and the result is loaded; s_ready stays low
//   until then, so a new frame is taken only after the last one is done.
//   With no taps no reads are issued and the output is the input frame halved.
//   Reset clears the write position and fill flag; history entries not yet
//   written read as silence, so there is no clearing pass.
//   If the receiver stalls, the result holds in the output register and the
//   next item is taken and processed; it waits for the register to free.
//   Registers must be written over APB only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module stereo_multi_tap_echo_unit
    import sme_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_ECHOES    = MAX_ECHOES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  frame_in_t         s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output frame_out_t        m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int KMAX = (MAX_ECHOES < TAP_K_MAX) ? MAX_ECHOES : TAP_K_MAX;
    localparam int KW   = $clog2(KMAX + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    cfg_t cfg;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          full_reg, full_next;
    logic [AW-1:0] dly_reg, dly_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] taps_reg, taps_next;
    frame_in_t     in_reg;

    logic          m_valid_reg, m_valid_next;
    frame_out_t    m_data_reg;

    logic          s_fire, issue, res_load, tap_busy;
    logic [AW:0]   idx_wide, dly_sum;
    logic [AW-1:0] rd_idx;
    tap_ctl_t      ctl;
    logic [2*SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0]   acc_l, acc_r;
    logic [SAMPLE_W:0]     sum_l, sum_r, half_l, half_r;

    sme_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid & s_ready;
    assign issue   = (state_reg == ST_ISSUE);

    // read index = pos - delay, wrapped into the history
    always_comb begin
        idx_wide = {1'b0, pos_reg} - {1'b0, dly_reg};
        if (idx_wide[AW]) begin
            idx_wide = idx_wide + (AW+1)'(HISTORY_DEPTH);
        end
        rd_idx = idx_wide[AW-1:0];
        dly_sum = {1'b0, dly_reg} + (AW+1)'(cfg.tap_spacing);
        if (dly_sum >= (AW+1)'(HISTORY_DEPTH)) begin
            dly_sum = dly_sum - (AW+1)'(HISTORY_DEPTH);
        end
        ctl.valid     = issue;
        ctl.k         = TAP_K_W'(k_reg);
        ctl.unwritten = ~full_reg & (rd_idx > pos_reg);
    end

    sme_hist_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (pos_reg),
        .wr_data ({s_data.right_sample, s_data.left_sample}),
        .rd_en   (issue),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    sme_tap_unit u_tap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .acc_clear (s_fire),
        .ctl_in    (ctl),
        .rd_data   (rd_data),
        .busy      (tap_busy),
        .acc_l     (acc_l),
        .acc_r     (acc_r)
    );

    assign res_load = (state_reg == ST_DRAIN) & ~tap_busy & (~m_valid_reg | m_ready);

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        full_next  = full_reg;
        dly_next   = dly_reg;
        k_next     = k_reg;
        taps_next  = taps_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    taps_next = (cfg.echo_count > 5'(KMAX)) ? KW'(KMAX) : KW'(cfg.echo_count);
                    k_next    = KW'(1);
                    dly_next  = AW'(cfg.tap_spacing);
                    state_next = (cfg.echo_count == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                dly_next = dly_sum[AW-1:0];
                k_next   = k_reg + KW'(1);
                if (k_reg == taps_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (res_load) begin
                    state_next = ST_IDLE;
                    if (pos_reg == AW'(HISTORY_DEPTH - 1)) begin
                        pos_next  = '0;
                        full_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + AW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            full_reg  <= 1'b0;
            dly_reg   <= '0;
            k_reg     <= '0;
            taps_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            full_reg  <= full_next;
            dly_reg   <= dly_next;
            k_reg     <= k_next;
            taps_reg  <= taps_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
    end

    // (input + echo) / 2, truncated toward zero
    always_comb begin
        sum_l  = {in_reg.left_sample[SAMPLE_W-1], in_reg.left_sample}
               + {acc_l[SAMPLE_W-1], acc_l};
        sum_r  = {in_reg.right_sample[SAMPLE_W-1], in_reg.right_sample}
               + {acc_r[SAMPLE_W-1], acc_r};
        half_l = sum_l + (SAMPLE_W+1)'(sum_l[SAMPLE_W]);
        half_r = sum_r + (SAMPLE_W+1)'(sum_r[SAMPLE_W]);
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg.left_out  <= half_l[SAMPLE_W:1];
            m_data_reg.right_out <= half_r[SAMPLE_W:1];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/sme_cfg_regs.sv
// ----------------------------------------------------------------------------
// sme_cfg_regs
// APB register file holding tap spacing, echo count, polarity and divider mode.
// ----------------------------------------------------------------------------
module sme_cfg_regs
    import sme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_spacing        <= TAP_SPACING_RST;
            cfg_reg.echo_count         <= ECHO_COUNT_RST;
            cfg_reg.alternate_polarity <= ALT_POLARITY_RST;
            cfg_reg.divider_mode       <= DIVIDER_MODE_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_TAP_SPACING:  cfg_reg.tap_spacing        <= pwdata[7:0];
                REG_ECHO_COUNT:   cfg_reg.echo_count         <= pwdata[4:0];
                REG_ALT_POLARITY: cfg_reg.alternate_polarity <= pwdata[0];
                REG_DIVIDER_MODE: cfg_reg.divider_mode       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_TAP_SPACING:  prdata[7:0] = cfg_reg.tap_spacing;
            REG_ECHO_COUNT:   prdata[4:0] = cfg_reg.echo_count;
            REG_ALT_POLARITY: prdata[0]   = cfg_reg.alternate_polarity;
            REG_DIVIDER_MODE: prdata[0]   = cfg_reg.divider_mode;
            default:          prdata      = '0;
        endcase
    end

endmodule

// File: hdl/sme_hist_ram.sv
// ----------------------------------------------------------------------------
// sme_hist_ram
// Frame history memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sme_hist_ram
    import sme_pkg::*;
#(
    parameter int DEPTH = HISTORY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [2*SAMPLE_W-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [2*SAMPLE_W-1:0] rd_data
);

    logic [2*SAMPLE_W-1:0] mem [DEPTH];
    logic [2*SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/sme_tap_unit.sv
// ----------------------------------------------------------------------------
// sme_tap_unit
// Per-tap datapath: polarity, division by k+1 or 2^k, wrapping accumulation.
// ----------------------------------------------------------------------------
module sme_tap_unit
    import sme_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  acc_clear,
    input  tap_ctl_t              ctl_in,
    input  logic [2*SAMPLE_W-1:0] rd_data,
    output logic                  busy,
    output logic [SAMPLE_W-1:0]   acc_l,
    output logic [SAMPLE_W-1:0]   acc_r
);

    tap_ctl_t ctl1_reg;
    tap_ctl_t ctl2_reg;

    logic [SAMPLE_W-1:0] smp_l, smp_r;
    logic [MAG_W-1:0]    mag_l, mag_r;
    logic                flip;
    logic [RECIP_W-1:0]  recip;

    logic [PROD_W-1:0]   prod_l_reg, prod_r_reg;
    logic [MAG_W-1:0]    shm_l_reg, shm_r_reg;
    logic                neg_l_reg, neg_r_reg;

    logic [MAG_W-1:0]    qm_l, qm_r, q_l, q_r;
    logic [SAMPLE_W-1:0] acc_l_reg, acc_r_reg, acc_l_next, acc_r_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    assign busy = ctl1_reg.valid | ctl2_reg.valid;

    // stage 1: magnitude and reciprocal multiply
    always_comb begin
        smp_l = ctl1_reg.unwritten ? '0 : rd_data[SAMPLE_W-1:0];
        smp_r = ctl1_reg.unwritten ? '0 : rd_data[2*SAMPLE_W-1:SAMPLE_W];
        mag_l = smp_l[SAMPLE_W-1] ? (MAG_W'(0) - {smp_l[SAMPLE_W-1], smp_l}) : {1'b0, smp_l};
        mag_r = smp_r[SAMPLE_W-1] ? (MAG_W'(0) - {smp_r[SAMPLE_W-1], smp_r}) : {1'b0, smp_r};
        flip  = cfg.alternate_polarity & ctl1_reg.k[0];
        recip = recip_of(ctl1_reg.k);
    end

    always_ff @(posedge aclk) begin
        prod_l_reg <= PROD_W'(mag_l) * PROD_W'(recip);
        prod_r_reg <= PROD_W'(mag_r) * PROD_W'(recip);
        shm_l_reg  <= mag_l >> ctl1_reg.k;
        shm_r_reg  <= mag_r >> ctl1_reg.k;
        neg_l_reg  <= smp_l[SAMPLE_W-1] ^ flip;
        neg_r_reg  <= smp_r[SAMPLE_W-1] ^ flip;
    end

    // stage 2: sign and accumulate
    always_comb begin
        qm_l = cfg.divider_mode ? shm_l_reg : prod_l_reg[PROD_W-1:RECIP_W];
        qm_r = cfg.divider_mode ? shm_r_reg : prod_r_reg[PROD_W-1:RECIP_W];
        q_l  = neg_l_reg ? (MAG_W'(0) - qm_l) : qm_l;
        q_r  = neg_r_reg ? (MAG_W'(0) - qm_r) : qm_r;
        acc_l_next = acc_l_reg;
        acc_r_next = acc_r_reg;
        if (acc_clear) begin
            acc_l_next = '0;
            acc_r_next = '0;
        end else if (ctl2_reg.valid) begin
            acc_l_next = acc_l_reg + q_l[SAMPLE_W-1:0];
            acc_r_next = acc_r_reg + q_r[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else begin
            acc_l_reg <= acc_l_next;
            acc_r_reg <= acc_r_next;
        end
    end

    assign acc_l = acc_l_reg;
    assign acc_r = acc_r_reg;

endmodule

// File: tb/sme_echo_checker.sv
// ----------------------------------------------------------------------------
// sme_echo_checker
// Watches the frame channels and the register port of the stereo echo unit.
// It keeps its own frame history and settings, and works out the mixed
// output frame for every input transfer. It checks each output transfer
// against the oldest mixed frame still due, and reports the mismatch count
// and the number of frames still due.
// ----------------------------------------------------------------------------
module sme_echo_checker
    import sme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  frame_in_t         s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  frame_out_t        m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = HISTORY_DEPTH_DEF;
    localparam int MAX_TAPS = MAX_ECHOES_DEF;

    // entry layout: left sample in [15:0], right sample in [31:16]
    logic [31:0] history_mem [DEPTH];
    int          wr_pos;
    logic [7:0]  spacing_q;
    logic [4:0]  count_q;
    logic        alt_q;
    logic        div_q;
    frame_out_t  mixed_due [$];

    function automatic logic [15:0] tap_term(input logic signed [15:0] s, input int k);
        int v;
        int q;
        v = s;
        if (alt_q && (k % 2 == 1))
            v = -v;
        if (div_q)
            q = (k >= 16) ? 0 : v / (1 << k);
        else
            q = v / (k + 1);
        return q[15:0];
    endfunction

    function automatic frame_out_t echo_mix_frame(input frame_in_t f);
        int          taps;
        int          delay;
        int          idx;
        logic [31:0] past;
        logic [15:0] acc_l;
        logic [15:0] acc_r;
        int          sum_l;
        int          sum_r;
        frame_out_t  r;
        taps  = (count_q > MAX_TAPS) ? MAX_TAPS : int'(count_q);
        acc_l = '0;
        acc_r = '0;
        for (int k = 1; k <= taps; k++) begin
            delay = (k * int'(spacing_q)) % DEPTH;
            idx   = (wr_pos + DEPTH - delay) % DEPTH;
            past  = history_mem[idx];
            acc_l = acc_l + tap_term(past[15:0], k);
            acc_r = acc_r + tap_term(past[31:16], k);
        end
        sum_l = (int'(f.left_sample) + int'($signed(acc_l))) / 2;
        sum_r = (int'(f.right_sample) + int'($signed(acc_r))) / 2;
        r.left_out  = sum_l[15:0];
        r.right_out = sum_r[15:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        frame_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++)
                history_mem[i] = '0;
            wr_pos    = 0;
            spacing_q = TAP_SPACING_RST;
            count_q   = ECHO_COUNT_RST;
            alt_q     = ALT_POLARITY_RST;
            div_q     = DIVIDER_MODE_RST;
            mixed_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TAP_SPACING:  spacing_q = pwdata[7:0];
                    REG_ECHO_COUNT:   count_q   = pwdata[4:0];
                    REG_ALT_POLARITY: alt_q     = pwdata[0];
                    REG_DIVIDER_MODE: div_q     = pwdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (mixed_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected output transfer L=%0d R=%0d", $realtime,
                                 m_data.left_out, m_data.right_out);
                    mismatches <= mismatches + 1;
                end else begin
                    want = mixed_due.pop_front();
                    if (m_data.left_out !== want.left_out ||
                        m_data.right_out !== want.right_out) begin
                        if (mismatches < 10)
                            $display("%0t: output mismatch exp L=%0d R=%0d got L=%0d R=%0d",
                                     $realtime, want.left_out, want.right_out,
                                     m_data.left_out, m_data.right_out);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                history_mem[wr_pos] = {s_data.right_sample, s_data.left_sample};
                mixed_due.push_back(echo_mix_frame(s_data));
                wr_pos = (wr_pos + 1) % DEPTH;
            end
            outstanding <= mixed_due.size();
        end
    end

endmodule

// File: tb/stereo_multi_tap_echo_unit_tb.sv
// ----------------------------------------------------------------------------
// stereo_multi_tap_echo_unit_tb
// Drives stereo frames and register writes into the echo unit with random
// bursts, gaps and receiver stalls, across many tap settings including the
// extremes; the checker beside the block predicts and compares every frame.
// ----------------------------------------------------------------------------
module stereo_multi_tap_echo_unit_tb
    import sme_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    frame_in_t         s_data;
    logic              m_valid;
    logic              m_ready;
    frame_out_t        m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;

    always #5 aclk = ~aclk;

    stereo_multi_tap_echo_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sme_echo_checker u_echo_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic write_reg(input logic [1:0] reg_id, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // lower valid, then wait until every mixed frame has been returned
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [7:0] spacing, input logic [4:0] count,
                                  input logic alt, input logic div, input logic junk);
        logic [31:0] hi;
        hi = junk ? $urandom : 32'h0;
        wait_drained();
        write_reg(REG_TAP_SPACING,  {hi[31:8], spacing});
        write_reg(REG_ECHO_COUNT,   {hi[31:5], count});
        write_reg(REG_ALT_POLARITY, {hi[31:1], alt});
        write_reg(REG_DIVIDER_MODE, {hi[31:1], div});
    endtask

    // valid stays high after the transfer; callers lower it for a gap
    task automatic send_frame(input frame_in_t f);
        s_valid <= 1'b1;
        s_data  <= f;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pair(input logic [15:0] l, input logic [15:0] r);
        frame_in_t f;
        f.left_sample  = l;
        f.right_sample = r;
        send_frame(f);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'($urandom_range(0, 63)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stretches, with a long hold-off every so often
    initial begin
        int stretch_no;
        int len;
        int mode;
        stretch_no = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stretch_no++;
            len = $urandom_range(4, 40);
            if (stretch_no % 50 == 0) begin
                m_ready <= 1'b0;
                repeat (250) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 2);
                repeat (len) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        default: m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        int        phase;
        int        sent;
        int        burst;
        logic [7:0] spacing;
        logic [4:0] count;
        logic       alt;
        logic       div;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, history still silent
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'h0000);
        send_pair(16'h0001, 16'hFFFF);

        // zero spacing: every tap reads the current frame
        apply_settings(8'd0, 5'd16, 1'b1, 1'b0, 1'b0);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'hFFFF, 16'h0001);
        send_pair(16'd12345, -16'sd12345);

        // exponential divider up to the zero sixteenth term
        apply_settings(8'd1, 5'd16, 1'b1, 1'b1, 1'b0);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h1234, 16'hEDCB);

        // no taps
        apply_settings(8'd3, 5'd0, 1'b0, 1'b0, 1'b0);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'hFFFF, 16'h0001);

        // echo count above the tap limit, upper register bits filled with random data
        apply_settings(8'd2, 5'd31, 1'b1, 1'b0, 1'b1);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'h5A5A, 16'hA5A5);

        for (phase = 0; phase < 14; phase++) begin
            case (phase)
                0: begin spacing = 8'd1;   count = 5'd16; alt = 1'b1; div = 1'b0; end
                1: begin spacing = 8'd255; count = 5'd16; alt = 1'b0; div = 1'b1; end
                2: begin spacing = 8'd1;   count = 5'd1;  alt = 1'b0; div = 1'b0; end
                3: begin spacing = 8'd7;   count = 5'd16; alt = 1'b1; div = 1'b1; end
                default: begin
                    spacing = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(1, 24));
                    count   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                         : 5'($urandom_range(1, 16));
                    alt     = 1'($urandom_range(0, 1));
                    div     = 1'($urandom_range(0, 1));
                end
            endcase
            apply_settings(spacing, count, alt, div, 1'($urandom_range(0, 1)));
            sent = 0;
            while (sent < 125) begin
                burst = $urandom_range(1, 40);
                while (burst > 0 && sent < 125) begin
                    send_pair(rand_sample(), rand_sample());
                    sent++;
                    burst--;
                end
                case ($urandom_range(0, 9)) inside
                    [0:5]:   idle_gap($urandom_range(1, 25));
                    6:       idle_gap($urandom_range(30, 80));
                    7:       wait_drained();
                    default: ;
                endcase
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[stereo_multi_tap_echo_unit] OK");
        end else begin
            $display("[stereo_multi_tap_echo_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[stereo_multi_tap_echo_unit] ERROR");
        $finish;
    end

endmodule
